/* rtl/core/omtt_pkg.sv */
// ----------------------------------------------------------------------------
// omtt_pkg: shared types and constants of the OBJ text tokenizer
// Token kinds, character codes, the result record and the byte classifiers.
// ----------------------------------------------------------------------------
package omtt_pkg;

   localparam int OFFSET_W = 24;
   localparam int LINE_W   = 20;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
   localparam logic [LINE_W-1:0]   LINE_MAX   = {LINE_W{1'b1}};

   typedef enum logic [3:0] {
      K_END     = 4'd0,
      K_ERROR   = 4'd1,
      K_NEWLINE = 4'd2,
      K_DOT     = 4'd3,
      K_MINUS   = 4'd4,
      K_SLASH   = 4'd5,
      K_NUMBER  = 4'd6,
      K_IDENT   = 4'd7,
      K_F       = 4'd8,
      K_G       = 4'd9,
      K_O       = 4'd10,
      K_S       = 4'd11,
      K_V       = 4'd12,
      K_VT      = 4'd13,
      K_VN      = 4'd14
   } token_kind_type;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_LF_F  = 8'h66;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_LN    = 8'h6E;
   localparam logic [7:0] CH_LO    = 8'h6F;
   localparam logic [7:0] CH_LS    = 8'h73;
   localparam logic [7:0] CH_LT    = 8'h74;
   localparam logic [7:0] CH_LV    = 8'h76;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   typedef struct packed {
      token_kind_type        kind;
      logic [OFFSET_W-1:0]   offset;
      logic [OFFSET_W-1:0]   length;
      logic [LINE_W-1:0]     line;
      logic                  last;
   } token_type;

   // up to two tokens produced by one byte, oldest in tok0
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic logic is_numeral(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
             (c == CH_USCORE);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) ||
             (c == CH_FF);
   endfunction

   function automatic token_kind_type ident_kind(input logic [7:0] first,
                                                 input logic [7:0] second,
                                                 input logic [OFFSET_W-1:0] len);
      token_kind_type k;
      k = K_IDENT;
      if (len == OFFSET_W'(1)) begin
         case (first)
            CH_LF_F: k = K_F;
            CH_LG:   k = K_G;
            CH_LO:   k = K_O;
            CH_LS:   k = K_S;
            CH_LV:   k = K_V;
            default: k = K_IDENT;
         endcase
      end else if ((len == OFFSET_W'(2)) && (first == CH_LV)) begin
         if (second == CH_LT) begin
            k = K_VT;
         end else if (second == CH_LN) begin
            k = K_VN;
         end
      end
      return k;
   endfunction

endpackage

/* rtl/core/omtt_if.sv */
// ----------------------------------------------------------------------------
// omtt_req_if / omtt_rsp_if: valid/ready channels of the OBJ text tokenizer
// Text byte channel and token channel.
// ----------------------------------------------------------------------------
interface omtt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface omtt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [3:0]                    token_kind;
   logic [omtt_pkg::OFFSET_W-1:0] token_offset;
   logic [omtt_pkg::OFFSET_W-1:0] token_length;
   logic [omtt_pkg::LINE_W-1:0]   token_line;
   logic                          last_of_run;

   modport source (output valid, output token_kind, output token_offset,
                   output token_length, output token_line, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_offset,
                   input token_length, input token_line, input last_of_run,
                   output ready);
endinterface

/* rtl/core/omtt_lex.sv */
// ----------------------------------------------------------------------------
// omtt_lex: lexer state and per-byte token decision
// Consumes one byte per fire and produces zero, one or two tokens.
// ----------------------------------------------------------------------------
module omtt_lex (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        text_byte,
   output omtt_pkg::push_type push
);

   typedef enum logic [2:0] {
      M_IDLE,
      M_COMMENT,
      M_IDENT,
      M_NUM_INT,
      M_NUM_FRAC,
      M_NUM_EXP,
      M_NUM_EXPD
   } mode_type;

   mode_type                      mode_ff, mode_in;
   logic [omtt_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [omtt_pkg::OFFSET_W-1:0] begin_ff, begin_in;
   logic [omtt_pkg::LINE_W-1:0]   line_ff, line_in;
   logic [7:0]                    first_ff, first_in;
   logic [7:0]                    second_ff, second_in;

   logic [omtt_pkg::OFFSET_W-1:0] len;
   logic [omtt_pkg::OFFSET_W-1:0] adv;
   logic                          cont;
   logic                          emit_prev;
   logic                          emit_cur;
   omtt_pkg::token_kind_type      prev_kind;
   omtt_pkg::token_kind_type      cur_kind;
   logic [omtt_pkg::OFFSET_W-1:0] cur_len;
   omtt_pkg::token_type           prev_tok;
   omtt_pkg::token_type           cur_tok;

   assign len = (offset_ff >= begin_ff) ? (offset_ff - begin_ff)
                                        : {omtt_pkg::OFFSET_W{1'b0}};
   assign adv = (offset_ff != omtt_pkg::OFFSET_MAX) ? (offset_ff + omtt_pkg::OFFSET_W'(1))
                                                   : offset_ff;

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      begin_in  = begin_ff;
      line_in   = line_ff;
      first_in  = first_ff;
      second_in = second_ff;
      cont      = 1'b0;
      emit_prev = 1'b0;
      emit_cur  = 1'b0;
      prev_kind = omtt_pkg::K_NUMBER;
      cur_kind  = omtt_pkg::K_ERROR;
      cur_len   = omtt_pkg::OFFSET_W'(1);

      // continue or close the token in progress
      case (mode_ff)
         M_COMMENT: begin
            if ((text_byte != omtt_pkg::CH_NUL) && (text_byte != omtt_pkg::CH_LF)) begin
               cont = 1'b1;
            end
         end
         M_IDENT: begin
            if (omtt_pkg::is_letter(text_byte) || omtt_pkg::is_numeral(text_byte)) begin
               cont = 1'b1;
               if (len == omtt_pkg::OFFSET_W'(1)) begin
                  second_in = text_byte;
               end
            end else begin
               emit_prev = 1'b1;
               prev_kind = omtt_pkg::ident_kind(first_ff, second_ff, len);
            end
         end
         M_NUM_INT: begin
            if (omtt_pkg::is_numeral(text_byte)) begin
               cont = 1'b1;
            end else if (text_byte == omtt_pkg::CH_DOT) begin
               mode_in = M_NUM_FRAC;
               cont    = 1'b1;
            end else if ((text_byte == omtt_pkg::CH_LE) || (text_byte == omtt_pkg::CH_UE)) begin
               mode_in = M_NUM_EXP;
               cont    = 1'b1;
            end else begin
               emit_prev = 1'b1;
            end
         end
         M_NUM_FRAC: begin
            if (omtt_pkg::is_numeral(text_byte)) begin
               cont = 1'b1;
            end else if ((text_byte == omtt_pkg::CH_LE) || (text_byte == omtt_pkg::CH_UE)) begin
               mode_in = M_NUM_EXP;
               cont    = 1'b1;
            end else begin
               emit_prev = 1'b1;
            end
         end
         M_NUM_EXP: begin
            if ((text_byte == omtt_pkg::CH_MINUS) || omtt_pkg::is_numeral(text_byte)) begin
               mode_in = M_NUM_EXPD;
               cont    = 1'b1;
            end else begin
               emit_prev = 1'b1;
            end
         end
         M_NUM_EXPD: begin
            if (omtt_pkg::is_numeral(text_byte)) begin
               cont = 1'b1;
            end else begin
               emit_prev = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (cont) begin
         offset_in = adv;
      end else begin
         mode_in = M_IDLE;
         if (text_byte == omtt_pkg::CH_NUL) begin
            emit_cur  = 1'b1;
            cur_kind  = omtt_pkg::K_END;
            cur_len   = {omtt_pkg::OFFSET_W{1'b0}};
            offset_in = {omtt_pkg::OFFSET_W{1'b0}};
            begin_in  = {omtt_pkg::OFFSET_W{1'b0}};
            line_in   = {omtt_pkg::LINE_W{1'b0}};
         end else if (omtt_pkg::is_blank(text_byte)) begin
            offset_in = adv;
         end else if (text_byte == omtt_pkg::CH_HASH) begin
            mode_in   = M_COMMENT;
            offset_in = adv;
         end else if (omtt_pkg::is_letter(text_byte)) begin
            mode_in   = M_IDENT;
            begin_in  = offset_ff;
            first_in  = text_byte;
            second_in = 8'h00;
            offset_in = adv;
         end else if (omtt_pkg::is_numeral(text_byte)) begin
            mode_in   = M_NUM_INT;
            begin_in  = offset_ff;
            offset_in = adv;
         end else if (text_byte == omtt_pkg::CH_DOT) begin
            emit_cur  = 1'b1;
            cur_kind  = omtt_pkg::K_DOT;
            offset_in = adv;
         end else if (text_byte == omtt_pkg::CH_MINUS) begin
            emit_cur  = 1'b1;
            cur_kind  = omtt_pkg::K_MINUS;
            offset_in = adv;
         end else if (text_byte == omtt_pkg::CH_SLASH) begin
            emit_cur  = 1'b1;
            cur_kind  = omtt_pkg::K_SLASH;
            offset_in = adv;
         end else if (text_byte == omtt_pkg::CH_LF) begin
            emit_cur  = 1'b1;
            cur_kind  = omtt_pkg::K_NEWLINE;
            offset_in = adv;
            if (line_ff != omtt_pkg::LINE_MAX) begin
               line_in = line_ff + omtt_pkg::LINE_W'(1);
            end
         end else begin
            emit_cur  = 1'b1;
            cur_kind  = omtt_pkg::K_ERROR;
            offset_in = adv;
         end
      end
   end

   always_comb begin
      prev_tok.kind   = prev_kind;
      prev_tok.offset = begin_ff;
      prev_tok.length = len;
      prev_tok.line   = line_ff;
      prev_tok.last   = !emit_cur;
      cur_tok.kind    = cur_kind;
      cur_tok.offset  = offset_ff;
      cur_tok.length  = cur_len;
      cur_tok.line    = line_ff;
      cur_tok.last    = 1'b1;

      push.tok0  = emit_prev ? prev_tok : cur_tok;
      push.tok1  = cur_tok;
      push.count = fire ? (2'(emit_prev) + 2'(emit_cur)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         offset_ff <= '0;
         begin_ff  <= '0;
         line_ff   <= '0;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         begin_ff  <= begin_in;
         line_ff   <= line_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

/* rtl/core/omtt_fifo.sv */
// ----------------------------------------------------------------------------
// omtt_fifo: four-entry token queue
// Takes up to two tokens per cycle, hands out one per cycle in order when popped.
// ----------------------------------------------------------------------------
module omtt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  omtt_pkg::push_type  push,
   input  logic                pop,
   output logic                room,
   output logic                not_empty,
   output omtt_pkg::token_type head
);

   omtt_pkg::token_type entry_ff [4];
   logic [1:0]          wr_ff, wr_in;
   logic [1:0]          rd_ff, rd_in;
   logic [2:0]          count_ff, count_in;
   logic                do_pop;

   assign not_empty = (count_ff != 3'd0);
   assign room      = (count_ff <= 3'd2);
   assign do_pop    = pop && not_empty;
   assign head      = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff + push.count;
      rd_in    = rd_ff + 2'(do_pop);
      count_in = count_ff + 3'(push.count) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ff + 2'd1] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/obj_mesh_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// obj_mesh_text_tokenizer: streaming lexer for Wavefront OBJ text
// Flow: an accepted byte waits in the input register until the queue has room,
//   is then lexed, and its tokens are written to the queue and offered from it.
// Throughput: one byte per cycle while the queue has room; a byte that closes a
//   token and emits a second one puts two tokens on the single token port.
// Reset: synchronous, clears the lexer state, the counters and the queue.
// ----------------------------------------------------------------------------
module obj_mesh_text_tokenizer (
   input  logic        clock,
   input  logic        reset,
   omtt_req_if.sink    req_chan,
   omtt_rsp_if.source  rsp_chan
);

   // input register: one byte waiting to be lexed
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;

   logic                fire;
   logic                room;
   logic                not_empty;
   logic                req_take;
   omtt_pkg::push_type  push;
   omtt_pkg::token_type head;

   // lex the held byte once the queue can absorb two tokens
   assign fire     = in_valid_ff && room;
   // take a new byte whenever the input register is free or drains this cycle
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register: no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   omtt_lex u_lex (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .text_byte (in_byte_ff),
      .push      (push)
   );

   // queue parts the lexer from a stalled token consumer
   omtt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_chan.ready),
      .room      (room),
      .not_empty (not_empty),
      .head      (head)
   );

   // drive the token transaction from the queue head
   assign rsp_chan.valid        = not_empty;
   assign rsp_chan.token_kind   = head.kind;
   assign rsp_chan.token_offset = head.offset;
   assign rsp_chan.token_length = head.length;
   assign rsp_chan.token_line   = head.line;
   assign rsp_chan.last_of_run  = head.last;

endmodule

/* rtl/core/omtt_checker.sv */
// ----------------------------------------------------------------------------
// omtt_checker: port-level checks of the OBJ text tokenizer
// Watches the token channel and is bound to the top level.
// ----------------------------------------------------------------------------
module omtt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [3:0]                    rsp_kind,
   input logic [omtt_pkg::OFFSET_W-1:0] rsp_length,
   input logic                          rsp_last
);

   // a stalled transaction stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("token valid dropped while stalled");

   // nothing is offered right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token offered after reset");

   // end token has zero length and closes its run
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == omtt_pkg::K_END) |-> (rsp_length == '0) && rsp_last)
      else $error("bad end token");

   // only a closed number or identifier can precede a second token
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_kind == omtt_pkg::K_NUMBER) ||
                                (rsp_kind == omtt_pkg::K_IDENT) ||
                                (rsp_kind == omtt_pkg::K_F) || (rsp_kind == omtt_pkg::K_G) ||
                                (rsp_kind == omtt_pkg::K_O) || (rsp_kind == omtt_pkg::K_S) ||
                                (rsp_kind == omtt_pkg::K_V) || (rsp_kind == omtt_pkg::K_VT) ||
                                (rsp_kind == omtt_pkg::K_VN))
      else $error("unexpected non-final token kind");

   // a single-byte token has length one
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == omtt_pkg::K_DOT) || (rsp_kind == omtt_pkg::K_MINUS) ||
                    (rsp_kind == omtt_pkg::K_SLASH) || (rsp_kind == omtt_pkg::K_NEWLINE) ||
                    (rsp_kind == omtt_pkg::K_ERROR))
      |-> (rsp_length == omtt_pkg::OFFSET_W'(1)) && rsp_last)
      else $error("bad single-byte token");

endmodule

bind obj_mesh_text_tokenizer omtt_checker u_omtt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.token_kind),
   .rsp_length (rsp_chan.token_length),
   .rsp_last   (rsp_chan.last_of_run)
);
